// ===== src/crcbh_pkg.sv =====
`timescale 1ns / 1ps

package crcbh_pkg;

    // Reflected Castagnoli polynomial and the starting value of every hash.
    localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
    localparam logic [31:0] HASH_SEED = 32'h0000_01FF;

    // One input word carries six 64-bit fields, 48 bytes in all.
    localparam int FIELD_W    = 64;
    localparam int NUM_FIELDS = 6;
    localparam int DATA_W     = FIELD_W * NUM_FIELDS;
    localparam int NUM_BYTES  = DATA_W / 8;

    typedef logic [31:0]       crc_t;
    typedef logic [DATA_W-1:0] blk_data_t;

    // Advance the reflected CRC by one byte, one polynomial step per bit.
    function automatic crc_t crc_byte(input crc_t crc_in, input logic [7:0] data_byte);
        crc_t acc;
        acc = crc_in ^ {24'h0, data_byte};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

// ===== src/crcbh_cell.sv =====
`timescale 1ns / 1ps

module crcbh_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  crcbh_pkg::crc_t    in_crc,
    input  crcbh_pkg::blk_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output crcbh_pkg::crc_t    out_crc,
    output crcbh_pkg::blk_data_t out_data
);
    import crcbh_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    crc_t      crc_reg;
    crc_t      crc_next;
    blk_data_t data_reg;
    blk_data_t data_next;
    logic      load;

    // The cell takes a new word when it is empty or its neighbor takes the current one.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Fold the lowest byte into the CRC and move the remaining bytes down.
    always_comb begin
        valid_next = valid_reg;
        crc_next   = crc_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (load) begin
            crc_next  = crc_byte(in_crc, in_data[7:0]);
            data_next = in_data >> 8;
        end
    end

    // Valid is control state; the CRC and data ride along without reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg  <= crc_next;
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_crc   = crc_reg;
    assign out_data  = data_reg;

    // A word held by a stalled neighbor keeps its CRC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_crc)))
        else $error("crcbh_cell: held CRC changed under stall");

    // An empty cell always accepts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid |-> in_ready)
        else $error("crcbh_cell: empty cell refused a word");

    // A loaded word shows up in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> out_valid)
        else $error("crcbh_cell: accepted word lost");

endmodule

// ===== src/crc32c_block_hash_4x4_yuv420.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                                    Content
// s_        in         s_valid, s_ready, s_luma_row0..3,        4x4 luma, 2x2 Cb, 2x2 Cr
//                      s_cb_quad, s_cr_quad                     as 16-bit samples
// m_        out        m_valid, m_ready, m_block_hash           32-bit Castagnoli CRC hash
//
// A chain of 48 cells, one per sample byte, each folding one byte into the CRC.
// Throughput is one word per cycle unless m_ready stalls; each word passes all 48 cells.
// The last cell's register is the output register; a stalled result stalls only
// the cells behind it that are full, so empty cells keep taking words.
// aresetn is synchronous and active low; it empties the chain.
module crc32c_block_hash_4x4_yuv420 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_luma_row0,
    input  logic [63:0] s_luma_row1,
    input  logic [63:0] s_luma_row2,
    input  logic [63:0] s_luma_row3,
    input  logic [63:0] s_cb_quad,
    input  logic [63:0] s_cr_quad,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_block_hash
);
    import crcbh_pkg::*;

    logic      chain_valid [0:NUM_BYTES];
    logic      chain_ready [0:NUM_BYTES];
    crc_t      chain_crc   [0:NUM_BYTES];
    blk_data_t chain_data  [0:NUM_BYTES];

    // Bytes go in little-endian order: luma rows first, then Cb, then Cr.
    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];
    assign chain_crc[0]   = HASH_SEED;
    assign chain_data[0]  = {s_cr_quad, s_cb_quad, s_luma_row3, s_luma_row2,
                             s_luma_row1, s_luma_row0};

    // One cell per byte; the last cell hands on only spent data.
    for (genvar i = 0; i < NUM_BYTES; i++) begin : g_cell
        crcbh_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_crc    (chain_crc[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_crc   (chain_crc[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // The last cell drives the result channel.
    assign m_valid                = chain_valid[NUM_BYTES];
    assign chain_ready[NUM_BYTES] = m_ready;
    assign m_block_hash           = chain_crc[NUM_BYTES];

    // With the output taken, every cell can move, so the input is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("crc32c_block_hash_4x4_yuv420: input blocked while output drains");

    // A refused input means the output is full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("crc32c_block_hash_4x4_yuv420: input refused without output stall");

    // A result under stall keeps its hash.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_block_hash)))
        else $error("crc32c_block_hash_4x4_yuv420: stalled hash changed");

endmodule
